// ===== sv/rlpd_pkg.sv =====
// Package for the RLP item decoder: result kinds, error codes, modes,
// decoder phases and the state and result structures.
// No dependencies.
package rlpd_pkg;

  localparam int LEN_BITS = 64;

  localparam logic [2:0] MODE_BYTES = 3'd0;
  localparam logic [2:0] MODE_U64   = 3'd1;
  localparam logic [2:0] MODE_U256  = 3'd2;
  localparam logic [2:0] MODE_ADDR  = 3'd3;
  localparam logic [2:0] MODE_LIST  = 3'd4;

  localparam logic [63:0] U64_MAX_BYTES  = 64'd8;
  localparam logic [63:0] U256_MAX_BYTES = 64'd32;
  localparam logic [63:0] ADDR_LEN       = 64'd20;
  localparam logic [63:0] LONG_MIN_LEN   = 64'd56;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_HDR     = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_INT     = 3'd3,
    KIND_ERR     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_LZ        = 3'd2,
    ERR_NONCANON  = 3'd3,
    ERR_PREFIX    = 3'd4,
    ERR_OVERFLOW  = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  item_mode;
    logic [3:0]  len_bytes_left;
    logic [63:0] length_accum;
    logic [63:0] payload_left;
    logic [63:0] value_accum;
    logic        first_payload;
    logic        prefix_is_list;
  } dec_state_t;

  typedef struct packed {
    kind_t       kind;
    err_t        err;
    logic [63:0] plen;
    logic [63:0] value;
    logic        done;
  } dec_res_t;

endpackage

// ===== sv/rlpd_step.sv =====
// One decode step of the RLP item decoder: next state and result for one byte.
// Purely combinational; depends on rlpd_pkg.
module rlpd_step
  import rlpd_pkg::*;
(
  input  dec_state_t  st,
  input  logic [7:0]  in_byte,
  input  logic [63:0] bytes_after,
  input  logic [2:0]  mode,
  output dec_state_t  st_nxt,
  output dec_res_t    res
);

  function automatic dec_res_t mk(kind_t k, err_t e, logic [63:0] pl, logic [63:0] v,
                                  logic d);
    dec_res_t r;
    r.kind  = k;
    r.err   = e;
    r.plen  = pl;
    r.value = v;
    r.done  = d;
    return r;
  endfunction

  logic        hdr_go;
  logic [63:0] hdr_len;
  logic [63:0] acc_sh;
  logic [3:0]  lbl_dec;
  logic [63:0] pl_dec;
  logic [63:0] va_sh;
  logic [63:0] byte64;

  assign byte64  = {56'd0, in_byte};
  assign acc_sh  = {st.length_accum[55:0], in_byte};
  assign lbl_dec = st.len_bytes_left - 4'd1;
  assign pl_dec  = st.payload_left - 64'd1;
  assign va_sh   = {st.value_accum[55:0], in_byte};

  always_comb begin
    st_nxt  = st;
    res     = mk(KIND_NONE, ERR_OK, 64'd0, 64'd0, 1'b0);
    hdr_go  = 1'b0;
    hdr_len = 64'd0;
    unique case (st.phase)
      PH_LEN: begin
        if (st.length_accum == 64'd0 && in_byte == 8'd0) begin
          res = mk(KIND_ERR, ERR_LZ, 64'd0, 64'd0, 1'b1);
        end else if (st.length_accum[63:LEN_BITS-8] != '0) begin
          res = mk(KIND_ERR, ERR_OVERFLOW, 64'd0, 64'd0, 1'b1);
        end else begin
          st_nxt.length_accum   = acc_sh;
          st_nxt.len_bytes_left = lbl_dec;
          if (lbl_dec != 4'd0) begin
            res = mk(KIND_NONE, ERR_OK, 64'd0, 64'd0, 1'b0);
          end else if (acc_sh < LONG_MIN_LEN) begin
            res = mk(KIND_ERR, ERR_NONCANON, 64'd0, 64'd0, 1'b1);
          end else if (st.prefix_is_list) begin
            res = mk(KIND_HDR, ERR_OK, acc_sh, 64'd0, 1'b1);
          end else if (bytes_after < acc_sh) begin
            res = mk(KIND_ERR, ERR_SHORT, 64'd0, 64'd0, 1'b1);
          end else begin
            hdr_go  = 1'b1;
            hdr_len = acc_sh;
          end
        end
      end
      PH_PAYLOAD: begin
        if (st.first_payload && st.payload_left == 64'd1 && in_byte < 8'h80) begin
          res = mk(KIND_ERR, ERR_NONCANON, 64'd0, 64'd0, 1'b1);
        end else if (st.first_payload && st.item_mode == MODE_ADDR &&
                     st.payload_left != ADDR_LEN) begin
          res = mk(KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1);
        end else if (st.first_payload &&
                     (st.item_mode == MODE_U64 || st.item_mode == MODE_U256) &&
                     st.payload_left > 64'd1 && in_byte == 8'd0) begin
          res = mk(KIND_ERR, ERR_LZ, 64'd0, 64'd0, 1'b1);
        end else begin
          st_nxt.first_payload = 1'b0;
          st_nxt.payload_left  = pl_dec;
          if (st.item_mode == MODE_U64) begin
            st_nxt.value_accum = va_sh;
            if (pl_dec == 64'd0) begin
              res = mk(KIND_INT, ERR_OK, 64'd0, va_sh, 1'b1);
            end else begin
              res = mk(KIND_NONE, ERR_OK, 64'd0, 64'd0, 1'b0);
            end
          end else begin
            res = mk(KIND_PAYLOAD, ERR_OK, 64'd0, byte64, pl_dec == 64'd0);
          end
        end
      end
      default: begin
        st_nxt.phase          = PH_IDLE;
        st_nxt.item_mode      = mode;
        st_nxt.length_accum   = 64'd0;
        st_nxt.len_bytes_left = 4'd0;
        st_nxt.payload_left   = 64'd0;
        st_nxt.value_accum    = 64'd0;
        st_nxt.first_payload  = 1'b0;
        st_nxt.prefix_is_list = 1'b0;
        if (mode > MODE_LIST) begin
          res = mk(KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1);
        end else if (mode == MODE_LIST) begin
          if (in_byte < 8'hC0) begin
            res = mk(KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1);
          end else if (in_byte <= 8'hF7) begin
            res = mk(KIND_HDR, ERR_OK, {56'd0, in_byte - 8'hC0}, 64'd0, 1'b1);
          end else if (bytes_after < {56'd0, in_byte - 8'hF7}) begin
            res = mk(KIND_ERR, ERR_SHORT, 64'd0, 64'd0, 1'b1);
          end else begin
            st_nxt.prefix_is_list = 1'b1;
            st_nxt.len_bytes_left = 4'(in_byte - 8'hF7);
            st_nxt.phase          = PH_LEN;
          end
        end else if (in_byte >= 8'hC0) begin
          res = mk(KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1);
        end else if (in_byte < 8'h80) begin
          if (mode == MODE_ADDR) begin
            res = mk(KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1);
          end else if (mode == MODE_U64) begin
            res = mk(KIND_INT, ERR_OK, 64'd0, byte64, 1'b1);
          end else begin
            res = mk(KIND_PAYLOAD, ERR_OK, 64'd0, byte64, 1'b1);
          end
        end else if (in_byte <= 8'hB7) begin
          if (bytes_after < {56'd0, in_byte - 8'h80}) begin
            res = mk(KIND_ERR, ERR_SHORT, 64'd0, 64'd0, 1'b1);
          end else begin
            hdr_go  = 1'b1;
            hdr_len = {56'd0, in_byte - 8'h80};
          end
        end else if (bytes_after < {56'd0, in_byte - 8'hB7}) begin
          res = mk(KIND_ERR, ERR_SHORT, 64'd0, 64'd0, 1'b1);
        end else begin
          st_nxt.len_bytes_left = 4'(in_byte - 8'hB7);
          st_nxt.phase          = PH_LEN;
        end
      end
    endcase

    // A complete string header is checked against the expected item class.
    if (hdr_go) begin
      if (st_nxt.item_mode == MODE_U64 && hdr_len == 64'd0) begin
        res = mk(KIND_INT, ERR_OK, 64'd0, 64'd0, 1'b1);
      end else if (st_nxt.item_mode == MODE_U64 && hdr_len > U64_MAX_BYTES) begin
        res = mk(KIND_ERR, ERR_OVERFLOW, 64'd0, 64'd0, 1'b1);
      end else if (st_nxt.item_mode == MODE_U256 && hdr_len > U256_MAX_BYTES) begin
        res = mk(KIND_ERR, ERR_OVERFLOW, 64'd0, 64'd0, 1'b1);
      end else if (st_nxt.item_mode == MODE_ADDR && hdr_len != 64'd1 &&
                   hdr_len != ADDR_LEN) begin
        res = mk(KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1);
      end else if (hdr_len == 64'd0) begin
        res = mk(KIND_HDR, ERR_OK, 64'd0, 64'd0, 1'b1);
      end else begin
        st_nxt.phase         = PH_PAYLOAD;
        st_nxt.payload_left  = hdr_len;
        st_nxt.first_payload = 1'b1;
        st_nxt.value_accum   = 64'd0;
        if (st_nxt.item_mode == MODE_U64 ||
            (st_nxt.item_mode == MODE_ADDR && hdr_len == 64'd1)) begin
          res = mk(KIND_NONE, ERR_OK, 64'd0, 64'd0, 1'b0);
        end else begin
          res = mk(KIND_HDR, ERR_OK, hdr_len, 64'd0, 1'b0);
        end
      end
    end

    if (res.done) begin
      st_nxt.phase = PH_IDLE;
    end
  end

endmodule

// ===== sv/rlp_item_decoder.sv =====
// RLP item decoder top level: input register, one decode step, result register.
// Each accepted byte is registered, then its result is registered onto out_tvalid.
// One byte per cycle unless out_tready stalls; the input register frees as results load.
// Reset (rst_n low, synchronous) empties both registers and returns the decoder to idle.
// Depends on rlpd_pkg and rlpd_step.
module rlp_item_decoder
  import rlpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // [7:0] in_byte, [71:8] bytes_after
  input  logic [2:0]   in_tuser,   // [2:0] mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [2:0] error_code, [66:3] payload_length,
                                   // [130:67] value, [135:131] zero
  output logic [2:0]   out_tuser,  // [2:0] kind
  output logic         out_tlast   // item_done
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic [63:0] s1_after_r;
  logic [2:0]  s1_mode_r;
  dec_state_t  st_r;
  dec_state_t  st_nxt;
  dec_res_t    res_nxt;
  dec_res_t    res_r;
  logic        out_valid_r;
  logic        out_load;

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;

  rlpd_step u_step (
    .st          (st_r),
    .in_byte     (s1_byte_r),
    .bytes_after (s1_after_r),
    .mode        (s1_mode_r),
    .st_nxt      (st_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata[7:0];
      s1_after_r <= in_tdata[71:8];
      s1_mode_r  <= in_tuser;
    end
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.value, res_r.plen, res_r.err};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.done;

endmodule

// ===== sv/rlpd_checker.sv =====
// Port-level checks for the RLP item decoder, bound to the top level.
// Depends on rlpd_pkg and rlp_item_decoder.
module rlpd_checker
  import rlpd_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_error_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERR |-> out_tlast)
    else $error("error transaction does not end the item");

  a_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == KIND_ERR) == (out_tdata[2:0] != ERR_OK)))
    else $error("error code disagrees with kind");

  a_none_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_NONE |-> !out_tlast)
    else $error("empty result marked as item end");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind rlp_item_decoder rlpd_checker u_rlpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/tb_rlp_item_decoder.sv =====
// Self-checking testbench for rlp_item_decoder: a directed table, then random
// RLP items with random stalls on both stream ports, checked by a local decoder model.
// Depends on rlpd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_rlp_item_decoder;
  import rlpd_pkg::*;

  localparam logic [2:0] MODE_UNKNOWN = 3'd7;
  localparam int DIR_COUNT = 28;
  localparam int RANDOM_BYTES = 1500;
  localparam int CALM_AFTER = 1200;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0]  enc_byte;
    logic [63:0] after;
    logic [2:0]  mode;
  } stim_t;

  typedef struct {
    logic [7:0]  enc_byte;
    logic [63:0] after;
    logic [2:0]  mode;
    bit          typed;
    dec_res_t    res;
  } dir_row_t;

  localparam dec_res_t NO_RES = '{KIND_NONE, ERR_OK, 64'd0, 64'd0, 1'b0};

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [71:0]  in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  phase_t      dec_phase;
  logic [2:0]  cur_mode;
  logic [3:0]  len_bytes_todo;
  logic [63:0] len_value;
  logic [63:0] payload_todo;
  logic [63:0] int_value;
  logic        at_first_payload;
  logic        hdr_is_list;

  dec_res_t   rlp_expected [$];
  logic [7:0] item_raw [$];

  int  mismatch_count = 0;
  int  bytes_sent = 0;
  int  random_sent = 0;
  int  results_seen = 0;
  int  err_results = 0;
  int  items_closed = 0;
  bit  calm_tail = 1'b0;
  bit  hold_req = 1'b0;

  dir_row_t dir_rows [DIR_COUNT] = '{
    '{8'h00, 64'd0, MODE_BYTES, 1'b1, '{KIND_PAYLOAD, ERR_OK, 64'd0, 64'h00, 1'b1}},
    '{8'h7f, 64'hffff_ffff_ffff_ffff, MODE_U64, 1'b1,
      '{KIND_INT, ERR_OK, 64'd0, 64'h7f, 1'b1}},
    '{8'h41, 64'd3, MODE_ADDR, 1'b1, '{KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1}},
    '{8'h80, 64'd0, MODE_U64, 1'b1, '{KIND_INT, ERR_OK, 64'd0, 64'd0, 1'b1}},
    '{8'h80, 64'd0, MODE_U256, 1'b1, '{KIND_HDR, ERR_OK, 64'd0, 64'd0, 1'b1}},
    '{8'h80, 64'd0, MODE_ADDR, 1'b1, '{KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1}},
    '{8'h05, 64'd0, MODE_UNKNOWN, 1'b1, '{KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1}},
    '{8'hbf, 64'd0, MODE_LIST, 1'b1, '{KIND_ERR, ERR_PREFIX, 64'd0, 64'd0, 1'b1}},
    '{8'hf7, 64'd0, MODE_LIST, 1'b1, '{KIND_HDR, ERR_OK, 64'd55, 64'd0, 1'b1}},
    '{8'hff, 64'd7, MODE_LIST, 1'b1, '{KIND_ERR, ERR_SHORT, 64'd0, 64'd0, 1'b1}},
    '{8'hb8, 64'd0, MODE_BYTES, 1'b1, '{KIND_ERR, ERR_SHORT, 64'd0, 64'd0, 1'b1}},
    '{8'h82, 64'd2, MODE_U64, 1'b1, NO_RES},
    '{8'h01, 64'd1, MODE_UNKNOWN, 1'b0, NO_RES},
    '{8'hfe, 64'd0, MODE_U64, 1'b0, NO_RES},
    '{8'h81, 64'd1, MODE_ADDR, 1'b1, NO_RES},
    '{8'h10, 64'd0, MODE_ADDR, 1'b1, '{KIND_ERR, ERR_NONCANON, 64'd0, 64'd0, 1'b1}},
    '{8'h81, 64'd1, MODE_ADDR, 1'b0, NO_RES},
    '{8'hff, 64'd0, MODE_ADDR, 1'b0, NO_RES},
    '{8'hb8, 64'd1, MODE_BYTES, 1'b0, NO_RES},
    '{8'h00, 64'd0, MODE_BYTES, 1'b0, NO_RES},
    '{8'hb8, 64'd1, MODE_BYTES, 1'b0, NO_RES},
    '{8'h37, 64'd55, MODE_BYTES, 1'b0, NO_RES},
    '{8'hf8, 64'd1, MODE_LIST, 1'b0, NO_RES},
    '{8'h40, 64'd0, MODE_LIST, 1'b0, NO_RES},
    '{8'h89, 64'd9, MODE_U64, 1'b1, '{KIND_ERR, ERR_OVERFLOW, 64'd0, 64'd0, 1'b1}},
    '{8'ha1, 64'd33, MODE_U256, 1'b1, '{KIND_ERR, ERR_OVERFLOW, 64'd0, 64'd0, 1'b1}},
    '{8'h82, 64'd2, MODE_U256, 1'b0, NO_RES},
    '{8'h00, 64'd1, MODE_U256, 1'b0, NO_RES}
  };

  rlp_item_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic dec_res_t res_of(input kind_t k, input err_t e, input logic [63:0] p,
                                      input logic [63:0] v, input logic d);
    dec_res_t r;
    r.kind = k;
    r.err = e;
    r.plen = p;
    r.value = v;
    r.done = d;
    return r;
  endfunction

  function automatic dec_res_t failure(input err_t e);
    return res_of(KIND_ERR, e, 64'd0, 64'd0, 1'b1);
  endfunction

  function automatic dec_res_t string_header(input logic [63:0] len);
    if (cur_mode == MODE_U64 && len == 64'd0) return res_of(KIND_INT, ERR_OK, 64'd0, 64'd0, 1'b1);
    if ((cur_mode == MODE_U64 && len > U64_MAX_BYTES) ||
        (cur_mode == MODE_U256 && len > U256_MAX_BYTES)) return failure(ERR_OVERFLOW);
    if (cur_mode == MODE_ADDR && len != 64'd1 && len != ADDR_LEN) return failure(ERR_PREFIX);
    if (len == 64'd0) return res_of(KIND_HDR, ERR_OK, 64'd0, 64'd0, 1'b1);
    dec_phase = PH_PAYLOAD;
    payload_todo = len;
    at_first_payload = 1'b1;
    int_value = 64'd0;
    if (cur_mode == MODE_U64 || (cur_mode == MODE_ADDR && len == 64'd1)) return NO_RES;
    return res_of(KIND_HDR, ERR_OK, len, 64'd0, 1'b0);
  endfunction

  function automatic dec_res_t rlp_decode_byte(input logic [7:0] b, input logic [63:0] after,
                                               input logic [2:0] mode);
    dec_res_t r;
    logic [63:0] wide_b;
    r = NO_RES;
    wide_b = {56'd0, b};
    if (dec_phase == PH_LEN) begin
      if (len_value == 64'd0 && b == 8'd0) begin
        r = failure(ERR_LZ);
      end else if ((len_value >> (LEN_BITS - 8)) != 64'd0) begin
        r = failure(ERR_OVERFLOW);
      end else begin
        len_value = {len_value[55:0], b};
        len_bytes_todo = len_bytes_todo - 4'd1;
        if (len_bytes_todo != 4'd0) r = NO_RES;
        else if (len_value < LONG_MIN_LEN) r = failure(ERR_NONCANON);
        else if (hdr_is_list) r = res_of(KIND_HDR, ERR_OK, len_value, 64'd0, 1'b1);
        else if (after < len_value) r = failure(ERR_SHORT);
        else r = string_header(len_value);
      end
    end else if (dec_phase == PH_PAYLOAD) begin
      if (at_first_payload && payload_todo == 64'd1 && b < 8'h80) begin
        r = failure(ERR_NONCANON);
      end else if (at_first_payload && cur_mode == MODE_ADDR && payload_todo != ADDR_LEN) begin
        r = failure(ERR_PREFIX);
      end else if (at_first_payload && (cur_mode == MODE_U64 || cur_mode == MODE_U256) &&
                   payload_todo > 64'd1 && b == 8'd0) begin
        r = failure(ERR_LZ);
      end else begin
        at_first_payload = 1'b0;
        payload_todo = payload_todo - 64'd1;
        if (cur_mode == MODE_U64) begin
          int_value = {int_value[55:0], b};
          if (payload_todo == 64'd0) r = res_of(KIND_INT, ERR_OK, 64'd0, int_value, 1'b1);
        end else begin
          r = res_of(KIND_PAYLOAD, ERR_OK, 64'd0, wide_b, payload_todo == 64'd0);
        end
      end
    end else begin
      cur_mode = mode;
      len_value = 64'd0;
      len_bytes_todo = 4'd0;
      payload_todo = 64'd0;
      int_value = 64'd0;
      at_first_payload = 1'b0;
      hdr_is_list = 1'b0;
      if (mode > MODE_LIST) begin
        r = failure(ERR_PREFIX);
      end else if (mode == MODE_LIST) begin
        if (b < 8'hc0) begin
          r = failure(ERR_PREFIX);
        end else if (b <= 8'hf7) begin
          r = res_of(KIND_HDR, ERR_OK, wide_b - 64'hc0, 64'd0, 1'b1);
        end else if (after < wide_b - 64'hf7) begin
          r = failure(ERR_SHORT);
        end else begin
          hdr_is_list = 1'b1;
          len_bytes_todo = 4'(b - 8'hf7);
          dec_phase = PH_LEN;
        end
      end else if (b >= 8'hc0) begin
        r = failure(ERR_PREFIX);
      end else if (b < 8'h80) begin
        if (mode == MODE_ADDR) r = failure(ERR_PREFIX);
        else if (mode == MODE_U64) r = res_of(KIND_INT, ERR_OK, 64'd0, wide_b, 1'b1);
        else r = res_of(KIND_PAYLOAD, ERR_OK, 64'd0, wide_b, 1'b1);
      end else if (b <= 8'hb7) begin
        if (after < wide_b - 64'h80) r = failure(ERR_SHORT);
        else r = string_header(wide_b - 64'h80);
      end else if (after < wide_b - 64'hb7) begin
        r = failure(ERR_SHORT);
      end else begin
        len_bytes_todo = 4'(b - 8'hb7);
        dec_phase = PH_LEN;
      end
    end
    if (r.done) dec_phase = PH_IDLE;
    return r;
  endfunction

  task automatic drive_byte(input stim_t s, input bit typed, input dec_res_t fixed);
    dec_res_t predicted;
    if (!calm_tail && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {s.after, s.enc_byte};
    in_tuser <= s.mode;
    do @(posedge clk); while (!in_tready);
    predicted = rlp_decode_byte(s.enc_byte, s.after, s.mode);
    rlp_expected.push_back(typed ? fixed : predicted);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic build_item(output logic [2:0] first_mode);
    logic [2:0]  m;
    int unsigned len;
    int unsigned lenlen;
    logic [7:0]  pay;
    item_raw.delete();
    m = 3'($urandom_range(0, 4));
    first_mode = m;
    case (m)
      MODE_ADDR: begin
        item_raw.push_back(8'h94);
        repeat (20) item_raw.push_back(8'($urandom_range(0, 255)));
      end
      MODE_LIST: begin
        if ($urandom_range(0, 2) == 0) begin
          lenlen = $urandom_range(1, 8);
          item_raw.push_back(8'(8'hf7 + lenlen));
          item_raw.push_back(8'(lenlen == 1 ? $urandom_range(56, 255) : $urandom_range(1, 255)));
          repeat (lenlen - 1) item_raw.push_back(8'($urandom_range(0, 255)));
        end else begin
          item_raw.push_back(8'(8'hc0 + $urandom_range(0, 55)));
        end
      end
      default: begin
        if (m == MODE_U64) len = $urandom_range(0, 8);
        else if (m == MODE_U256) len = $urandom_range(0, 32);
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(56, 72);
        else len = $urandom_range(0, 55);
        if (len == 1 && $urandom_range(0, 1) == 1) begin
          item_raw.push_back(8'($urandom_range(0, 127)));
        end else begin
          if (len <= 55) begin
            item_raw.push_back(8'(8'h80 + len));
          end else begin
            item_raw.push_back(8'hb8);
            item_raw.push_back(8'(len));
          end
          for (int i = 0; i < len; i++) begin
            pay = 8'($urandom_range(0, 255));
            if (i == 0 && len == 1) pay[7] = 1'b1;
            if (i == 0 && len > 1 && m != MODE_BYTES && pay == 8'd0) pay = 8'd1;
            item_raw.push_back(pay);
          end
        end
      end
    endcase
  endtask

  task automatic send_random_item();
    logic [2:0]  first_mode;
    logic [63:0] tail;
    int unsigned n;
    int unsigned send_n;
    int unsigned damage;
    stim_t       s;
    build_item(first_mode);
    n = item_raw.size();
    send_n = n;
    tail = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 20));
    damage = $urandom_range(0, 11);
    case (damage)
      0: item_raw[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
      1: tail = 64'd0 - 64'($urandom_range(1, n));
      2: first_mode = 3'($urandom_range(0, 7));
      3: if (n > 1) send_n = n - $urandom_range(1, n - 1);
      default: ;
    endcase
    for (int i = 0; i < send_n; i++) begin
      s.enc_byte = item_raw[i];
      s.after = 64'(n - 1 - i) + tail;
      s.mode = (i == 0) ? first_mode : 3'($urandom_range(0, 7));
      drive_byte(s, 1'b0, NO_RES);
      random_sent++;
      if (random_sent > CALM_AFTER) calm_tail = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
    if (mismatch_count < 10)
      $display("Mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
               field, results_seen, want_v, got_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    dec_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser == KIND_ERR) err_results++;
      if (out_tlast) items_closed++;
      if (rlp_expected.size() == 0) begin
        report_mismatch("unexpected result kind", 64'd0, 64'(out_tuser));
      end else begin
        want = rlp_expected.pop_front();
        if (out_tuser !== want.kind) report_mismatch("kind", 64'(want.kind), 64'(out_tuser));
        if (out_tdata[2:0] !== want.err)
          report_mismatch("error_code", 64'(want.err), 64'(out_tdata[2:0]));
        if (out_tdata[66:3] !== want.plen)
          report_mismatch("payload_length", want.plen, out_tdata[66:3]);
        if (out_tdata[130:67] !== want.value)
          report_mismatch("value", want.value, out_tdata[130:67]);
        if (out_tlast !== want.done) report_mismatch("item_done", 64'(want.done), 64'(out_tlast));
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    stim_t s;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    dec_phase = PH_IDLE;
    cur_mode = MODE_BYTES;
    len_bytes_todo = 4'd0;
    len_value = 64'd0;
    payload_todo = 64'd0;
    int_value = 64'd0;
    at_first_payload = 1'b0;
    hdr_is_list = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < DIR_COUNT; i++) begin
      s.enc_byte = dir_rows[i].enc_byte;
      s.after = dir_rows[i].after;
      s.mode = dir_rows[i].mode;
      drive_byte(s, dir_rows[i].typed, dir_rows[i].res);
    end
    hold_req = 1'b1;
    while (random_sent < RANDOM_BYTES) send_random_item();
    in_tvalid <= 1'b0;
    while (rlp_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d byte transactions (%0d from the directed table) across all five modes.",
             bytes_sent, DIR_COUNT);
    $display("Checked %0d results: %0d decode errors, %0d completed items.",
             results_seen, err_results, items_closed);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding.", rlp_expected.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== rlp_item_decoder.f =====
sv/rlpd_pkg.sv
sv/rlpd_step.sv
sv/rlp_item_decoder.sv
sv/rlpd_checker.sv
test/tb_rlp_item_decoder.sv
